@@ rtl/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// lkv_pkg
// shared codes and handshake structs of the lru key-value cache
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PROBE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PUT_REFRESH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_GET_MISS    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PROBE_MISS  = 3'd4;

    // handshake from top level into the sequencer
    typedef struct packed {
        logic req_valid;
        logic res_take;
    } t_seq_in;

    // handshake from the sequencer to the top level
    typedef struct packed {
        logic req_ready;
        logic res_valid;
    } t_seq_out;

endpackage

@@ rtl/lkv_ifs.sv @@
// ----------------------------------------------------------------------------
// lkv_ifs
// request, response and capacity write channels of the cache
// ----------------------------------------------------------------------------
interface lkv_req_if #(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
);
    logic                       valid;
    logic                       ready;
    logic [lkv_pkg::FUNC_W-1:0] func;
    logic [KEY_WIDTH-1:0]       key;
    logic [VALUE_WIDTH-1:0]     value_in;

    modport source (output valid, output func, output key, output value_in, input ready);
    modport sink   (input valid, input func, input key, input value_in, output ready);
endinterface

interface lkv_rsp_if #(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32,
    parameter int OCC_WIDTH   = 5
);
    logic                         valid;
    logic                         ready;
    logic [lkv_pkg::STATUS_W-1:0] status;
    logic [VALUE_WIDTH-1:0]       value_out;
    logic                         evicted;
    logic [KEY_WIDTH-1:0]         evicted_key;
    logic [OCC_WIDTH-1:0]         occupancy;

    modport source (output valid, output status, output value_out, output evicted,
                    output evicted_key, output occupancy, input ready);
    modport sink   (input valid, input status, input value_out, input evicted,
                    input evicted_key, input occupancy, output ready);
endinterface

interface lkv_cfg_if #(
    parameter int DATA_WIDTH = 5
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                              request when
//  i_req     in   func, key, value_in                                  valid & ready
//  o_rsp     out  status, value_out, evicted, evicted_key, occupancy   valid & ready
//  i_cfg     in   data (capacity)                                      valid & ready
//
//  one request at a time; a search pass reads every entry from the tag, value
//  and rank memories, one entry per cycle, then a plan cycle decides the slot
//  get hit and any put then take a second pass over the rank memory, which
//  also writes key and value for an insert; probes and get misses skip it
//  synchronous active-low reset clears valid marks, occupancy and sets capacity
//  a response held by a stalled sink blocks the next request only once the
//  sequencer has its next response ready
//
module lru_key_value_cache #(
    parameter int DEPTH       = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32,
    localparam int CNTW       = $clog2(DEPTH + 1)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lkv_req_if.sink   i_req,
    lkv_rsp_if.source o_rsp,
    lkv_cfg_if.sink   i_cfg
);

    lkv_pkg::t_seq_in              seq_in;
    lkv_pkg::t_seq_out             seq_out;

    // capacity register
    logic [CNTW-1:0]               r_capacity;

    // response output register
    logic                          r_out_vld;
    logic [lkv_pkg::STATUS_W-1:0]  r_out_status;
    logic [VALUE_WIDTH-1:0]        r_out_vout;
    logic                          r_out_ev;
    logic [KEY_WIDTH-1:0]          r_out_evk;
    logic [CNTW-1:0]               r_out_occ;

    logic [lkv_pkg::STATUS_W-1:0]  res_status;
    logic [VALUE_WIDTH-1:0]        res_vout;
    logic                          res_ev;
    logic [KEY_WIDTH-1:0]          res_evk;
    logic [CNTW-1:0]               res_occ;
    logic                          load;

    // output register takes a response when empty or draining this cycle
    assign load = seq_out.res_valid && (!r_out_vld || o_rsp.ready);

    assign seq_in.req_valid = i_req.valid;
    assign seq_in.res_take  = load;
    assign i_req.ready      = seq_out.req_ready;
    assign i_cfg.ready      = 1'b1;

    lkv_ctrl #(
        .DEPTH       (DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_hs          (seq_in),
        .o_hs          (seq_out),
        .i_func        (i_req.func),
        .i_key         (i_req.key),
        .i_value_in    (i_req.value_in),
        .i_capacity    (r_capacity),
        .o_status      (res_status),
        .o_value_out   (res_vout),
        .o_evicted     (res_ev),
        .o_evicted_key (res_evk),
        .o_occupancy   (res_occ)
    );

    // capacity write, reset to the full depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CNTW'(DEPTH);
        end else if (i_cfg.valid) begin
            r_capacity <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_status <= res_status;
            r_out_vout   <= res_vout;
            r_out_ev     <= res_ev;
            r_out_evk    <= res_evk;
            r_out_occ    <= res_occ;
        end
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.value_out   = r_out_vout;
    assign o_rsp.evicted     = r_out_ev;
    assign o_rsp.evicted_key = r_out_evk;
    assign o_rsp.occupancy   = r_out_occ;

    // occupancy never beyond the entry count
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.occupancy <= CNTW'(DEPTH)))
        else $error("occupancy above depth");

    // only an insert can evict
    a_evict_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.evicted) |-> (o_rsp.status == lkv_pkg::ST_INSERTED))
        else $error("eviction without insert");

    // a request in flight blocks the next one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while busy");

    // value only returned on a hit
    a_value_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.value_out != '0)) |-> (o_rsp.status == lkv_pkg::ST_HIT))
        else $error("value returned without hit");

endmodule

@@ rtl/lkv_ram.sv @@
// ----------------------------------------------------------------------------
// lkv_ram
// simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lkv_ram #(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH      = 16,
    localparam int AW        = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lkv_ctrl.sv @@
// ----------------------------------------------------------------------------
// lkv_ctrl
// scan sequencer: search pass over all entries, plan step, rank update pass
// ----------------------------------------------------------------------------
module lkv_ctrl #(
    parameter int DEPTH       = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32,
    localparam int AW         = $clog2(DEPTH),
    localparam int CNTW       = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lkv_pkg::t_seq_in             i_hs,
    output lkv_pkg::t_seq_out            o_hs,
    input  logic [lkv_pkg::FUNC_W-1:0]   i_func,
    input  logic [KEY_WIDTH-1:0]         i_key,
    input  logic [VALUE_WIDTH-1:0]       i_value_in,
    input  logic [CNTW-1:0]              i_capacity,
    output logic [lkv_pkg::STATUS_W-1:0] o_status,
    output logic [VALUE_WIDTH-1:0]       o_value_out,
    output logic                         o_evicted,
    output logic [KEY_WIDTH-1:0]         o_evicted_key,
    output logic [CNTW-1:0]              o_occupancy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_PLAN = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                   r_state, n_state;
    logic [CNTW-1:0]              r_cnt;
    logic                         r_pvld;
    logic [AW-1:0]                r_pidx;
    logic [DEPTH-1:0]             r_valid;
    logic [CNTW-1:0]              r_count;

    logic [lkv_pkg::FUNC_W-1:0]   r_func;
    logic [KEY_WIDTH-1:0]         r_key;
    logic [VALUE_WIDTH-1:0]       r_val;

    // search captures
    logic                         r_hit;
    logic [AW-1:0]                r_hit_idx;
    logic [AW-1:0]                r_hit_rank;
    logic [VALUE_WIDTH-1:0]       r_hit_val;
    logic                         r_free;
    logic [AW-1:0]                r_free_idx;
    logic                         r_lru;
    logic [AW-1:0]                r_lru_idx;
    logic [AW-1:0]                r_lru_rank;
    logic [KEY_WIDTH-1:0]         r_lru_key;

    // update plan
    logic [AW-1:0]                r_slot;
    logic [AW-1:0]                r_thr;
    logic                         r_incr_all;
    logic                         r_write_kv;

    // result
    logic [lkv_pkg::STATUS_W-1:0] r_res_status;
    logic [VALUE_WIDTH-1:0]       r_res_vout;
    logic                         r_res_ev;
    logic [KEY_WIDTH-1:0]         r_res_evk;

    logic [KEY_WIDTH-1:0]         key_q;
    logic [VALUE_WIDTH-1:0]       val_q;
    logic [AW-1:0]                rank_q;
    logic                         vld_p;
    logic                         last_p;
    logic                         find_p;
    logic                         upd_p;
    logic                         rank_we;
    logic [AW-1:0]                rank_wdata;
    logic                         kv_we;
    logic [CNTW-1:0]              eff_cap;
    logic                         full;
    logic                         do_upd;
    logic                         accept;

    lkv_ram #(.DATA_WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (kv_we),
        .i_waddr (r_pidx),
        .i_wdata (r_key),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (key_q)
    );

    lkv_ram #(.DATA_WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (kv_we),
        .i_waddr (r_pidx),
        .i_wdata (r_val),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (val_q)
    );

    lkv_ram #(.DATA_WIDTH(AW), .DEPTH(DEPTH)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rank_we),
        .i_waddr (r_pidx),
        .i_wdata (rank_wdata),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (rank_q)
    );

    assign accept = (r_state == S_IDLE) && i_hs.req_valid;
    assign vld_p  = r_valid[r_pidx];
    assign last_p = r_pvld && (r_pidx == AW'(DEPTH - 1));
    assign find_p = (r_state == S_FIND) && r_pvld;
    assign upd_p  = (r_state == S_UPD) && r_pvld;

    always_comb begin
        eff_cap = i_capacity;
        if (i_capacity == '0) begin
            eff_cap = CNTW'(1);
        end else if (i_capacity > CNTW'(DEPTH)) begin
            eff_cap = CNTW'(DEPTH);
        end
    end

    assign full   = (r_count >= eff_cap) && (r_count != '0);
    assign do_upd = ((r_func == lkv_pkg::FUNC_GET) && r_hit) ||
                    (r_func == lkv_pkg::FUNC_PUT);

    // update pass: target slot goes to rank zero, others age as planned
    always_comb begin
        rank_we    = 1'b0;
        rank_wdata = '0;
        kv_we      = 1'b0;
        if (upd_p) begin
            if (r_pidx == r_slot) begin
                rank_we = 1'b1;
                kv_we   = r_write_kv;
            end else if (vld_p && (r_incr_all || (rank_q < r_thr))) begin
                rank_we    = 1'b1;
                rank_wdata = rank_q + AW'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                if (last_p) begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                n_state = do_upd ? S_UPD : S_DONE;
            end
            S_UPD: begin
                if (last_p) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_hs.res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pvld  <= 1'b0;
            r_valid <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_FIND) || (r_state == S_UPD)) begin
                r_pvld <= (r_cnt != CNTW'(DEPTH));
                if (r_cnt != CNTW'(DEPTH)) begin
                    r_cnt <= r_cnt + CNTW'(1);
                end
            end else begin
                r_pvld <= 1'b0;
                r_cnt  <= '0;
            end
            if (upd_p && (r_pidx == r_slot)) begin
                r_valid[r_slot] <= 1'b1;
            end
            if ((r_state == S_PLAN) && (r_func == lkv_pkg::FUNC_PUT) && !r_hit && !full) begin
                r_count <= r_count + CNTW'(1);
            end
        end
    end

    // request latch, search captures, plan and result
    always_ff @(posedge i_clk) begin
        r_pidx <= r_cnt[AW-1:0];
        if (accept) begin
            r_func <= i_func;
            r_key  <= i_key;
            r_val  <= i_value_in;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
            r_lru  <= 1'b0;
        end
        if (find_p) begin
            if (vld_p && (key_q == r_key) && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_pidx;
                r_hit_rank <= rank_q;
                r_hit_val  <= val_q;
            end
            if (!vld_p && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_pidx;
            end
            if (vld_p && (!r_lru || (rank_q > r_lru_rank))) begin
                r_lru      <= 1'b1;
                r_lru_idx  <= r_pidx;
                r_lru_rank <= rank_q;
                r_lru_key  <= key_q;
            end
        end
        if (r_state == S_PLAN) begin
            r_res_vout <= '0;
            r_res_ev   <= 1'b0;
            r_res_evk  <= '0;
            r_slot     <= r_hit_idx;
            r_thr      <= r_hit_rank;
            r_incr_all <= 1'b0;
            r_write_kv <= 1'b0;
            case (r_func)
                lkv_pkg::FUNC_GET: begin
                    if (r_hit) begin
                        r_res_status <= lkv_pkg::ST_HIT;
                        r_res_vout   <= r_hit_val;
                    end else begin
                        r_res_status <= lkv_pkg::ST_GET_MISS;
                    end
                end
                lkv_pkg::FUNC_PUT: begin
                    if (r_hit) begin
                        r_res_status <= lkv_pkg::ST_PUT_REFRESH;
                    end else begin
                        r_res_status <= lkv_pkg::ST_INSERTED;
                        r_incr_all   <= 1'b1;
                        r_write_kv   <= 1'b1;
                        if (full) begin
                            r_slot    <= r_lru_idx;
                            r_res_ev  <= 1'b1;
                            r_res_evk <= r_lru_key;
                        end else begin
                            r_slot <= r_free_idx;
                        end
                    end
                end
                default: begin
                    r_res_status <= r_hit ? lkv_pkg::ST_HIT : lkv_pkg::ST_PROBE_MISS;
                end
            endcase
        end
    end

    assign o_hs.req_ready = (r_state == S_IDLE);
    assign o_hs.res_valid = (r_state == S_DONE);
    assign o_status       = r_res_status;
    assign o_value_out    = r_res_vout;
    assign o_evicted      = r_res_ev;
    assign o_evicted_key  = r_res_evk;
    assign o_occupancy    = r_count;

endmodule
